// ===== rtl/mppt_po_pkg.sv =====
// Package for the perturb-and-observe MPPT core.
// Fixed field widths, register reset values, register indexes and the config struct.
// No dependencies.
`default_nettype none

package mppt_po_pkg;

    localparam int DUTY_W  = 9;
    localparam int STEP_W  = 4;
    localparam int POWER_W = 24;

    localparam logic [DUTY_W-1:0]  DUTY_MAX_RST  = 9'd320;
    localparam logic [STEP_W-1:0]  DUTY_STEP_RST = 4'd1;
    localparam logic [POWER_W-1:0] POWER_MAX     = 24'hFF_FFFF;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_DUTY_MAX  = 1'b0,
        REG_DUTY_STEP = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_max;
        logic [STEP_W-1:0] duty_step;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/mppt_po_if.sv =====
// Stream interfaces for the MPPT core: sample pairs in, control-step results out.
// Depends on mppt_po_pkg for the result field widths.
`default_nettype none

interface mppt_po_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] voltage_sample;
    logic [SAMPLE_BITS-1:0] current_sample;

    modport source (output valid, output voltage_sample, output current_sample, input ready);
    modport sink   (input valid, input voltage_sample, input current_sample, output ready);
endinterface

interface mppt_po_out_if;
    logic                                valid;
    logic                                ready;
    logic [mppt_po_pkg::DUTY_W-1:0]      duty_value;
    logic [mppt_po_pkg::POWER_W-1:0]     power_value;
    logic                                going_up;

    modport source (output valid, output duty_value, output power_value, output going_up,
                    input ready);
    modport sink   (input valid, input duty_value, input power_value, input going_up,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/mppt_po_apb.sv =====
// APB-style register file for duty_max and duty_step.
// Depends on mppt_po_pkg (t_cfg, register indexes, reset values).
`default_nettype none

module mppt_po_apb (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output mppt_po_pkg::t_cfg        o_cfg
);
    import mppt_po_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    // word index only; byte offset bits do not select a register
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_max  <= DUTY_MAX_RST;
            r_cfg.duty_step <= DUTY_STEP_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_DUTY_MAX:  r_cfg.duty_max  <= pwdata[DUTY_W-1:0];
                REG_DUTY_STEP: r_cfg.duty_step <= pwdata[STEP_W-1:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = 32'd0;
        case (w_idx)
            REG_DUTY_MAX:  prdata = {{(32-DUTY_W){1'b0}}, r_cfg.duty_max};
            REG_DUTY_STEP: prdata = {{(32-STEP_W){1'b0}}, r_cfg.duty_step};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mppt_po_accum.sv =====
// Input stage: sums AVG_PAIRS sample pairs per channel and registers the two averages.
// Depends on mppt_po_in_if.
`default_nettype none

module mppt_po_accum #(
    parameter int AVG_PAIRS   = 8,
    parameter int SAMPLE_BITS = 12,
    parameter int SH          = $clog2(AVG_PAIRS + 1) - 1,
    parameter int AVG_W       = SAMPLE_BITS + $clog2(AVG_PAIRS) - SH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    mppt_po_in_if.sink            i_smp,
    output logic                  o_avg_valid,
    input  wire logic             i_avg_ready,
    output logic [AVG_W-1:0]      o_v_avg,
    output logic [AVG_W-1:0]      o_c_avg
);
    localparam int CNT_W = $clog2(AVG_PAIRS);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(AVG_PAIRS - 1);

    logic [SUM_W-1:0] r_v_sum, n_v_sum;
    logic [SUM_W-1:0] r_c_sum, n_c_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_avg_valid;
    logic [AVG_W-1:0] r_v_avg, r_c_avg;
    logic             w_acc;
    logic             w_last;

    // the average register can take a new group once it is empty or being drained
    assign i_smp.ready = !r_avg_valid || i_avg_ready;
    assign w_acc       = i_smp.valid && i_smp.ready;
    assign w_last      = (r_cnt == LAST_CNT);

    assign n_v_sum = r_v_sum + SUM_W'(i_smp.voltage_sample);
    assign n_c_sum = r_c_sum + SUM_W'(i_smp.current_sample);

    // running sums and pair counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sum <= '0;
            r_c_sum <= '0;
            r_cnt   <= '0;
        end else if (w_acc) begin
            if (w_last) begin
                r_v_sum <= '0;
                r_c_sum <= '0;
                r_cnt   <= '0;
            end else begin
                r_v_sum <= n_v_sum;
                r_c_sum <= n_c_sum;
                r_cnt   <= r_cnt + CNT_W'(1);
            end
        end
    end

    // average valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_valid <= 1'b0;
        end else if (w_acc && w_last) begin
            r_avg_valid <= 1'b1;
        end else if (i_avg_ready) begin
            r_avg_valid <= 1'b0;
        end
    end

    // averages: drop the low SH bits of the completed sums
    always_ff @(posedge i_clk) begin
        if (w_acc && w_last) begin
            r_v_avg <= n_v_sum[SUM_W-1:SH];
            r_c_avg <= n_c_sum[SUM_W-1:SH];
        end
    end

    assign o_avg_valid = r_avg_valid;
    assign o_v_avg     = r_v_avg;
    assign o_c_avg     = r_c_avg;

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST_CNT)
        else $error("pair counter beyond group size");

    a_group_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last) |=> (r_avg_valid && r_cnt == '0 && r_v_sum == '0))
        else $error("group end did not post averages and clear sums");

    a_avg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_avg_valid && !i_avg_ready) |=> (r_avg_valid && $stable(r_v_avg)))
        else $error("pending averages lost while stalled");

endmodule

`default_nettype wire

// ===== rtl/mppt_po_step.sv =====
// Control step: power from the averages, direction update, duty step with floor and cap,
// and the result register. Depends on mppt_po_pkg and mppt_po_out_if.
`default_nettype none

module mppt_po_step #(
    parameter int AVG_W = 12
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_avg_valid,
    output logic                   o_avg_ready,
    input  wire logic [AVG_W-1:0]  i_v_avg,
    input  wire logic [AVG_W-1:0]  i_c_avg,
    input  wire mppt_po_pkg::t_cfg i_cfg,
    mppt_po_out_if.source          o_res
);
    import mppt_po_pkg::*;

    localparam int PROD_W = 2 * AVG_W;

    logic [POWER_W-1:0] r_last_power;
    logic               r_dir;
    logic [DUTY_W-1:0]  r_duty_now;
    logic               r_out_valid;
    logic [DUTY_W-1:0]  r_duty_out;
    logic [POWER_W-1:0] r_power_out;
    logic               r_dir_out;

    logic [PROD_W-1:0]  w_prod;
    logic [POWER_W-1:0] w_power;
    logic               n_dir;
    logic [DUTY_W:0]    w_duty_pre;
    logic [DUTY_W-1:0]  n_duty;
    logic               w_adv;

    assign o_avg_ready = !r_out_valid || o_res.ready;
    assign w_adv       = i_avg_valid && o_avg_ready;

    // power, saturated to the result width
    assign w_prod = PROD_W'(i_v_avg) * PROD_W'(i_c_avg);

    generate
        if (PROD_W > POWER_W) begin : g_sat
            assign w_power = (|w_prod[PROD_W-1:POWER_W]) ? POWER_MAX : w_prod[POWER_W-1:0];
        end else begin : g_ext
            assign w_power = POWER_W'(w_prod);
        end
    endgenerate

    // direction flips only on a strict power drop
    assign n_dir = r_dir ^ (w_power < r_last_power);

    // duty step, floored at zero, then capped at duty_max
    always_comb begin
        if (n_dir) begin
            w_duty_pre = {1'b0, r_duty_now} + (DUTY_W + 1)'(i_cfg.duty_step);
        end else if (r_duty_now < DUTY_W'(i_cfg.duty_step)) begin
            w_duty_pre = '0;
        end else begin
            w_duty_pre = {1'b0, r_duty_now - DUTY_W'(i_cfg.duty_step)};
        end
        if (w_duty_pre > {1'b0, i_cfg.duty_max}) begin
            n_duty = i_cfg.duty_max;
        end else begin
            n_duty = w_duty_pre[DUTY_W-1:0];
        end
    end

    // tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_power <= '0;
            r_dir        <= 1'b1;
            r_duty_now   <= '0;
        end else if (w_adv) begin
            r_last_power <= w_power;
            r_dir        <= n_dir;
            r_duty_now   <= n_duty;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_duty_out  <= n_duty;
            r_power_out <= w_power;
            r_dir_out   <= n_dir;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.duty_value  = r_duty_out;
    assign o_res.power_value = r_power_out;
    assign o_res.going_up    = r_dir_out;

    // checks
    a_dir_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> ((r_dir != $past(r_dir)) == ($past(w_power) < $past(r_last_power))))
        else $error("direction changed without a power drop, or missed one");

    a_duty_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_duty_now <= $past(i_cfg.duty_max)))
        else $error("duty above configured maximum");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_duty_out == r_duty_now && r_dir_out == r_dir
                         && r_power_out == r_last_power))
        else $error("pending result out of step with tracker state");

endmodule

`default_nettype wire

// ===== rtl/mppt_perturb_observe_core.sv =====
// Top level of the perturb-and-observe MPPT core.
// Depends on mppt_po_pkg, mppt_po_if, mppt_po_apb, mppt_po_accum, mppt_po_step.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  i_smp    | in  | valid/ready        | voltage_sample, current_sample
//  o_res    | out | valid/ready        | duty_value, power_value, going_up
//  apb      | in  | psel/penable/pready| paddr, pwdata, pwrite -> prdata
//
// One sample pair is taken per cycle unless the input is stalled. The last pair of each
// AVG_PAIRS group posts the averages; the control step (one multiplier, compare, duty
// step) runs once the result register is free or being taken, and its result is registered.
// Reset is synchronous, active low; it clears sums, counter, direction (up), duty,
// last power and loads the register defaults. A held result stalls the input only
// when a further group completes before it is taken.
`default_nettype none

module mppt_perturb_observe_core #(
    parameter int AVG_PAIRS   = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    mppt_po_in_if.sink        i_smp,
    mppt_po_out_if.source     o_res,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);
    import mppt_po_pkg::*;

    localparam int SH    = $clog2(AVG_PAIRS + 1) - 1;
    localparam int AVG_W = SAMPLE_BITS + $clog2(AVG_PAIRS) - SH;

    t_cfg             w_cfg;
    logic             w_avg_valid;
    logic             w_avg_ready;
    logic [AVG_W-1:0] w_v_avg;
    logic [AVG_W-1:0] w_c_avg;

    // configuration registers
    mppt_po_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // accumulate and average
    mppt_po_accum #(
        .AVG_PAIRS   (AVG_PAIRS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SH          (SH),
        .AVG_W       (AVG_W)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (i_smp),
        .o_avg_valid (w_avg_valid),
        .i_avg_ready (w_avg_ready),
        .o_v_avg     (w_v_avg),
        .o_c_avg     (w_c_avg)
    );

    // control step and result register
    mppt_po_step #(
        .AVG_W (AVG_W)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avg_valid (w_avg_valid),
        .o_avg_ready (w_avg_ready),
        .i_v_avg     (w_v_avg),
        .i_c_avg     (w_c_avg),
        .i_cfg       (w_cfg),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for mppt_perturb_observe_core: directed and random sample streams,
// APB register writes, backpressure, and a scoreboard fed by an in-bench tracker model.
// Depends on mppt_po_pkg, mppt_po_if and the RTL of the core.
`default_nettype none

module tb;
    import mppt_po_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAIRS     = 8;   // sample pairs per control step
    localparam int AVG_SHIFT = 3;   // log2 of PAIRS
    localparam int SMP_MAX   = 4095;

    typedef struct {
        logic [DUTY_W-1:0]  duty;
        logic [POWER_W-1:0] power;
        logic               up;
    } t_step_res;

    logic clk = 1'b0;
    logic rst_n;

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mppt_po_in_if #(.SAMPLE_BITS(12)) smp_if ();
    mppt_po_out_if                    res_if ();

    mppt_perturb_observe_core #(
        .AVG_PAIRS   (PAIRS),
        .SAMPLE_BITS (12)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    // tracker model state and register copy
    logic [14:0]        v_acc      = '0;
    logic [14:0]        c_acc      = '0;
    logic [2:0]         pair_idx   = '0;
    logic [POWER_W-1:0] prev_power = '0;
    logic               dir_up     = 1'b1;
    logic [DUTY_W-1:0]  duty_now   = '0;
    logic [DUTY_W-1:0]  cfg_duty_max  = DUTY_MAX_RST;
    logic [STEP_W-1:0]  cfg_duty_step = DUTY_STEP_RST;

    t_step_res pending_steps[$];

    int err_count     = 0;
    int pairs_sent    = 0;
    int steps_checked = 0;
    int cfg_writes    = 0;
    int src_gap_pct   = 0;
    int sink_stall_pct = 0;
    int sink_hold     = 0;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Sum one pair; on the last pair of a group run the control step and queue its result
    task automatic accumulate_pair(input logic [11:0] v, input logic [11:0] c);
        logic [11:0]        v_avg;
        logic [11:0]        c_avg;
        logic [POWER_W-1:0] pw;
        logic [DUTY_W:0]    nd;
        t_step_res          r;
        v_acc = v_acc + v;
        c_acc = c_acc + c;
        if (pair_idx != 3'(PAIRS - 1)) begin
            pair_idx++;
            return;
        end
        pair_idx = '0;
        v_avg = 12'(v_acc >> AVG_SHIFT);
        c_avg = 12'(c_acc >> AVG_SHIFT);
        v_acc = '0;
        c_acc = '0;
        // 12x12 bits always fits 24 bits, no saturation reachable here
        pw = v_avg * c_avg;
        // only a strict drop reverses the direction
        if (pw < prev_power)
            dir_up = ~dir_up;
        prev_power = pw;
        if (dir_up)
            nd = {1'b0, duty_now} + cfg_duty_step;
        else if (duty_now < cfg_duty_step)
            nd = '0;
        else
            nd = {1'b0, duty_now} - cfg_duty_step;
        if (nd > cfg_duty_max)
            nd = {1'b0, cfg_duty_max};
        duty_now = nd[DUTY_W-1:0];
        r.duty  = duty_now;
        r.power = pw;
        r.up    = dir_up;
        pending_steps.push_back(r);
    endtask

    // One sample transfer, with an optional random gap before it
    task automatic send_pair(input logic [11:0] v, input logic [11:0] c);
        if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        smp_if.valid          <= 1'b1;
        smp_if.voltage_sample <= v;
        smp_if.current_sample <= c;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        accumulate_pair(v, c);
        pairs_sent++;
    endtask

    task automatic send_group(input logic [11:0] v, input logic [11:0] c);
        repeat (PAIRS) send_pair(v, c);
    endtask

    // Stop offering and wait until every queued step result is taken
    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_steps.size() != 0) @(posedge clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_writes++;
    endtask

    // Read one register back and compare with the expected value
    task automatic apb_check(input t_reg_idx idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d reads %0h, want %0h",
                                      idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Both registers, written only with the core idle; upper data bits carry noise
    task automatic set_config(input logic [DUTY_W-1:0] dmax, input logic [STEP_W-1:0] dstep);
        logic [31:0] word;
        wait_drained();
        repeat (4) @(posedge clk);
        word = $urandom;
        word[DUTY_W-1:0] = dmax;
        apb_write(REG_DUTY_MAX, word);
        cfg_duty_max = dmax;
        @(posedge clk);
        word = $urandom;
        word[STEP_W-1:0] = dstep;
        apb_write(REG_DUTY_STEP, word);
        cfg_duty_step = dstep;
        @(posedge clk);
        apb_check(REG_DUTY_MAX, 32'(dmax));
        @(posedge clk);
        apb_check(REG_DUTY_STEP, 32'(dstep));
    endtask

    function automatic logic [11:0] clamp_sample(input int x);
        if (x < 0)
            return 12'd0;
        if (x > SMP_MAX)
            return 12'(SMP_MAX);
        return 12'(x);
    endfunction

    // Register defaults: extremes of both fields, then a power drop and equal power
    task automatic test_reset_tracking();
        logic [11:0] v_pat[PAIRS] = '{12'h000, 12'hFFF, 12'hFFF, 12'h000,
                                      12'hAAA, 12'h555, 12'hFFF, 12'h800};
        logic [11:0] c_pat[PAIRS] = '{12'hFFF, 12'h000, 12'hFFF, 12'h000,
                                      12'h555, 12'hAAA, 12'h001, 12'h7FF};
        for (int i = 0; i < PAIRS; i++)
            send_pair(v_pat[i], c_pat[i]);
        send_group(12'd0, 12'd0);   // power drops: reverse to down
        send_group(12'd0, 12'd0);   // equal power, duty floored at zero
    endtask

    // Duty floor, cap, cap after lowering the limit, zero step, zero limit
    task automatic test_duty_limits();
        set_config(9'd20, 4'd15);
        send_group(12'hFFF, 12'hFFF);
        send_group(12'd0, 12'd0);
        send_group(12'd0, 12'd0);
        set_config(9'd10, 4'd15);
        send_group(12'd0, 12'd0);
        set_config(9'd511, 4'd0);
        send_group(12'd0, 12'd0);
        set_config(9'd0, 4'd15);
        send_group(12'd1, 12'd1);
    endtask

    // Result side held off long enough that the input stalls behind it
    task automatic test_output_backpressure();
        set_config(9'd511, 4'd3);
        src_gap_pct = 0;
        sink_hold   = 160;
        repeat (6 * PAIRS) send_pair(12'($urandom), 12'($urandom));
        wait_drained();
    endtask

    // Hill-climbing groups with drifting levels, mixed with unaligned random bursts
    task automatic test_random_tracking();
        int dmax_set[8]  = '{511, 0, 511, 1, -1, -1, -1, 320};
        int dstep_set[8] = '{15, 1, 1, 15, -1, 0, -1, 1};
        int v_base;
        int c_base;
        int sent;
        for (int ph = 0; ph < 8; ph++) begin
            set_config(dmax_set[ph] < 0 ? 9'($urandom) : 9'(dmax_set[ph]),
                       dstep_set[ph] < 0 ? 4'($urandom_range(1, 15)) : 4'(dstep_set[ph]));
            if (ph == 7) begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end else begin
                src_gap_pct    = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
                sink_stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(5, 40);
            end
            v_base = $urandom_range(0, SMP_MAX);
            c_base = $urandom_range(0, SMP_MAX);
            sent   = 0;
            while (sent < 175) begin
                if ($urandom_range(0, 3) != 0) begin
                    v_base = int'(clamp_sample(v_base + $urandom_range(0, 600) - 300));
                    c_base = int'(clamp_sample(c_base + $urandom_range(0, 600) - 300));
                    for (int i = 0; i < PAIRS; i++)
                        send_pair(clamp_sample(v_base + $urandom_range(0, 64) - 32),
                                  clamp_sample(c_base + $urandom_range(0, 64) - 32));
                    sent += PAIRS;
                end else begin
                    int n;
                    n = $urandom_range(1, PAIRS);
                    repeat (n) send_pair(12'($urandom), 12'($urandom));
                    sent += n;
                end
            end
        end
    endtask

    // Result receiver: random stall bursts, plus a long hold on request
    initial begin : sink_ready_gen
        res_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (sink_hold > 0) begin
                res_if.ready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
                res_if.ready <= 1'b1;
            end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Scoreboard: each result transfer against the oldest queued step
    always @(posedge clk) begin : res_check
        t_step_res exp_r;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_steps.size() == 0) begin
                report_mismatch($sformatf("unexpected result duty %0d power %0d up %0b",
                                          res_if.duty_value, res_if.power_value,
                                          res_if.going_up));
            end else begin
                exp_r = pending_steps.pop_front();
                steps_checked++;
                if (res_if.duty_value !== exp_r.duty)
                    report_mismatch($sformatf("step %0d duty_value %0d, want %0d",
                                              steps_checked, res_if.duty_value, exp_r.duty));
                if (res_if.power_value !== exp_r.power)
                    report_mismatch($sformatf("step %0d power_value %0d, want %0d",
                                              steps_checked, res_if.power_value, exp_r.power));
                if (res_if.going_up !== exp_r.up)
                    report_mismatch($sformatf("step %0d going_up %0b, want %0b",
                                              steps_checked, res_if.going_up, exp_r.up));
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : main_seq
        int n;
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        smp_if.valid          = 1'b0;
        smp_if.voltage_sample = '0;
        smp_if.current_sample = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_tracking();
        test_duty_limits();
        test_output_backpressure();
        test_random_tracking();

        // drain with a bound, then let the pipeline settle
        smp_if.valid <= 1'b0;
        n = 0;
        while (pending_steps.size() != 0 && n < 20000) begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
        if (pending_steps.size() != 0)
            report_mismatch($sformatf("%0d control steps never produced a result",
                                      pending_steps.size()));

        $display("Run: %0d sample pairs sent, %0d control step results checked,",
                 pairs_sent, steps_checked);
        $display("     %0d register writes incl. limit/step extremes and a long output hold.",
                 cfg_writes);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/mppt_po_pkg.sv
rtl/mppt_po_if.sv
rtl/mppt_po_apb.sv
rtl/mppt_po_accum.sv
rtl/mppt_po_step.sv
rtl/mppt_perturb_observe_core.sv
dv/tb.sv
